/* design/nzbb_pkg.sv */
// ----------------------------------------------------------------------------
// nzbb_pkg
// Shared types, register indexes and pixel format codes for the bounding
// box block.
// ----------------------------------------------------------------------------
package nzbb_pkg;

    localparam int BAND_W      = 8;
    localparam int BOX_W       = 10;
    localparam int CFG_W       = 11;
    localparam int IDX_W       = 2;
    localparam int FMT_W       = 2;
    localparam int DEF_MAX_DIM = 1024;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    // pixel formats
    localparam logic [FMT_W-1:0] FMT_L8   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_RGBA = 2'd2;

    typedef struct packed {
        logic             found;
        logic [BOX_W-1:0] left;
        logic [BOX_W-1:0] top;
        logic [BOX_W-1:0] right;
        logic [BOX_W-1:0] bottom;
    } t_box;

    // a pixel is ink when any band in use is non-zero; unused format code is rgb
    function automatic logic pixel_ink(
        input logic [FMT_W-1:0]  fmt,
        input logic [BAND_W-1:0] b0,
        input logic [BAND_W-1:0] b1,
        input logic [BAND_W-1:0] b2,
        input logic [BAND_W-1:0] b3
    );
        logic ink;
        case (fmt)
            FMT_L8:   ink = |b0;
            FMT_RGBA: ink = |{b0, b1, b2, b3};
            default:  ink = |{b0, b1, b2};
        endcase
        return ink;
    endfunction

endpackage

/* design/nzbb_cfg.sv */
// ----------------------------------------------------------------------------
// nzbb_cfg
// Configuration registers: pixel format and frame size, with the size
// clamped to 1..MAX_DIM as it is written.
// ----------------------------------------------------------------------------
module nzbb_cfg
    import nzbb_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    localparam int WW     = $clog2(MAX_DIM + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_cfg_ready,
    output logic [FMT_W-1:0] o_format,
    output logic [WW-1:0]    o_width,
    output logic [WW-1:0]    o_height
);

    localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;

    logic [FMT_W-1:0] r_format;
    logic [WW-1:0]    r_width;
    logic [WW-1:0]    r_height;
    logic [FMT_W-1:0] n_format;
    logic [WW-1:0]    n_width;
    logic [WW-1:0]    n_height;
    logic [WW-1:0]    clamped;

    function automatic logic [WW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [WW-1:0] d;
        if (v == '0) begin
            d = WW'(1);
        end else if (CMPW'(v) > CMPW'(MAX_DIM)) begin
            d = WW'(MAX_DIM);
        end else begin
            d = WW'(v);
        end
        return d;
    endfunction

    assign clamped = clamp_dim(i_cfg_data);

    always_comb begin
        n_format = r_format;
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FORMAT: n_format = i_cfg_data[FMT_W-1:0];
                REG_WIDTH:  n_width  = clamped;
                REG_HEIGHT: n_height = clamped;
                default:    ; // write beyond the register list is dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_RGBA;
            r_width  <= WW'(1);
            r_height <= WW'(1);
        end else begin
            r_format <= n_format;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_format    = r_format;
    assign o_width     = r_width;
    assign o_height    = r_height;

endmodule

/* design/nzbb_track.sv */
// ----------------------------------------------------------------------------
// nzbb_track
// Raster position counters and running min/max of the ink pixel positions.
// Flags the last pixel of the frame and presents the box including it.
// ----------------------------------------------------------------------------
module nzbb_track
    import nzbb_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    localparam int WW     = $clog2(MAX_DIM + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_process,
    input  logic          i_ink,
    input  logic [WW-1:0] i_width,
    input  logic [WW-1:0] i_height,
    output logic          o_frame_end,
    output t_box          o_box
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int PW = WW + 1;

    logic [CW-1:0] r_column, n_column;
    logic [CW-1:0] r_row,    n_row;
    logic          r_seen,   n_seen;
    logic [CW-1:0] r_min_col, n_min_col;
    logic [CW-1:0] r_min_row, n_min_row;
    logic [CW-1:0] r_max_col, n_max_col;
    logic [CW-1:0] r_max_row, n_max_row;
    logic          last_col;
    logic          last_row;

    // "at or beyond" so a shrunk frame size wraps at the next pixel
    assign last_col    = (PW'(r_column) + PW'(1)) >= PW'(i_width);
    assign last_row    = (PW'(r_row) + PW'(1)) >= PW'(i_height);
    assign o_frame_end = last_col && last_row;

    // box with the current pixel folded in
    always_comb begin
        n_seen    = r_seen;
        n_min_col = r_min_col;
        n_min_row = r_min_row;
        n_max_col = r_max_col;
        n_max_row = r_max_row;
        if (i_ink) begin
            n_seen = 1'b1;
            if (!r_seen) begin
                n_min_col = r_column;
                n_max_col = r_column;
                n_min_row = r_row;
                n_max_row = r_row;
            end else begin
                if (r_column < r_min_col) n_min_col = r_column;
                if (r_column > r_max_col) n_max_col = r_column;
                if (r_row < r_min_row)    n_min_row = r_row;
                if (r_row > r_max_row)    n_max_row = r_row;
            end
        end
    end

    always_comb begin
        n_column = r_column + CW'(1);
        n_row    = r_row;
        if (last_col) begin
            n_column = '0;
            n_row    = r_row + CW'(1);
        end
    end

    always_comb begin
        o_box.found  = n_seen;
        o_box.left   = n_seen ? BOX_W'(n_min_col) : '0;
        o_box.top    = n_seen ? BOX_W'(n_min_row) : '0;
        o_box.right  = n_seen ? BOX_W'(n_max_col) : '0;
        o_box.bottom = n_seen ? BOX_W'(n_max_row) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column  <= '0;
            r_row     <= '0;
            r_seen    <= 1'b0;
            r_min_col <= '0;
            r_min_row <= '0;
            r_max_col <= '0;
            r_max_row <= '0;
        end else if (i_process) begin
            if (o_frame_end) begin
                r_column  <= '0;
                r_row     <= '0;
                r_seen    <= 1'b0;
                r_min_col <= '0;
                r_min_row <= '0;
                r_max_col <= '0;
                r_max_row <= '0;
            end else begin
                r_column  <= n_column;
                r_row     <= n_row;
                r_seen    <= n_seen;
                r_min_col <= n_min_col;
                r_min_row <= n_min_row;
                r_max_col <= n_max_col;
                r_max_row <= n_max_row;
            end
        end
    end

endmodule

/* design/nonzero_pixel_bounding_box.sv */
// ----------------------------------------------------------------------------
// nonzero_pixel_bounding_box
// Bounding box of the non-empty pixels of a raster-order frame.
// ----------------------------------------------------------------------------
// Pixels come in on the input channel (i_in_valid / o_in_stall), one pixel
// per request, in raster order. Frame size and pixel format are set through
// the configuration channel (i_cfg_valid / o_cfg_ready, always ready); a size
// of zero counts as one and a size above MAX_DIM as MAX_DIM.
// After the last pixel of a frame one result leaves on the output channel
// (o_out_valid / i_out_stall): a found flag and the inclusive box, all zero
// when the frame held no ink. The frame state then clears for the next frame.
// A pixel is registered on acceptance and folded into the box from that
// register; the box of a frame-ending pixel is registered for output.
// Throughput is one pixel per cycle, set by the single compare-and-select
// stage of the tracker, except where a result held in the output register
// under stall stops the pixel that ends the next frame, and the input with it.
// Reset (synchronous, active low) empties the pipeline, clears the frame
// state and sets RGBA8888 with a 1 x 1 frame.
// ----------------------------------------------------------------------------
module nonzero_pixel_bounding_box
    import nzbb_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BAND_W-1:0] i_band_zero,
    input  logic [BAND_W-1:0] i_band_one,
    input  logic [BAND_W-1:0] i_band_two,
    input  logic [BAND_W-1:0] i_band_three,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_found,
    output logic [BOX_W-1:0]  o_box_left,
    output logic [BOX_W-1:0]  o_box_top,
    output logic [BOX_W-1:0]  o_box_right,
    output logic [BOX_W-1:0]  o_box_bottom
);

    localparam int WW = $clog2(MAX_DIM + 1);

    logic [FMT_W-1:0]  cfg_format;
    logic [WW-1:0]     cfg_width;
    logic [WW-1:0]     cfg_height;

    logic              r_pix_valid;
    logic [BAND_W-1:0] r_b0, r_b1, r_b2, r_b3;
    logic              r_out_valid;
    t_box              r_out_box;

    logic              in_accept;
    logic              out_free;
    logic              process;
    logic              frame_end;
    logic              ink;
    t_box              box;

    nzbb_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_format    (cfg_format),
        .o_width     (cfg_width),
        .o_height    (cfg_height)
    );

    assign ink = pixel_ink(cfg_format, r_b0, r_b1, r_b2, r_b3);

    nzbb_track #(
        .MAX_DIM (MAX_DIM)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_process   (process),
        .i_ink       (ink),
        .i_width     (cfg_width),
        .i_height    (cfg_height),
        .o_frame_end (frame_end),
        .o_box       (box)
    );

    // only a frame-ending pixel needs room in the output register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign process    = r_pix_valid && (!frame_end || out_free);
    assign o_in_stall = r_pix_valid && !process;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_pix_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_b0 <= i_band_zero;
            r_b1 <= i_band_one;
            r_b2 <= i_band_two;
            r_b3 <= i_band_three;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && frame_end) begin
            r_out_box <= box;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_box.found;
    assign o_box_left   = r_out_box.left;
    assign o_box_top    = r_out_box.top;
    assign o_box_right  = r_out_box.right;
    assign o_box_bottom = r_out_box.bottom;

endmodule

/* design/nzbb_checker.sv */
// ----------------------------------------------------------------------------
// nzbb_checker
// Port-level checks on the bounding box block, bound to the top level.
// ----------------------------------------------------------------------------
module nzbb_checker
    import nzbb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_found,
    input logic [BOX_W-1:0]  o_box_left,
    input logic [BOX_W-1:0]  o_box_top,
    input logic [BOX_W-1:0]  o_box_right,
    input logic [BOX_W-1:0]  o_box_bottom
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_found) && $stable(o_box_left) && $stable(o_box_top) &&
            $stable(o_box_right) && $stable(o_box_bottom))
        else $error("stalled result changed");

    // an empty frame reports an all-zero box
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |->
            o_box_left == '0 && o_box_top == '0 &&
            o_box_right == '0 && o_box_bottom == '0)
        else $error("box not zero for empty frame");

    // min never passes max
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |->
            o_box_left <= o_box_right && o_box_top <= o_box_bottom)
        else $error("box corners out of order");

endmodule

bind nonzero_pixel_bounding_box nzbb_checker u_nzbb_checker (.*);

/* tb/nonzero_pixel_bounding_box_tb.sv */
// ----------------------------------------------------------------------------
// nonzero_pixel_bounding_box_tb
// Streams raster frames of random and hand-picked pixels through the block
// and checks every bounding box it reports against a cycle-free tracker that
// scans the same accepted pixels with its own copy of the frame settings.
// Both channels idle and stall at random; the receiver also holds off for a
// long stretch so that the block backs up into its pixel input.
// ----------------------------------------------------------------------------
module nonzero_pixel_bounding_box_tb;
    import nzbb_pkg::*;

    localparam int IDLE_PCT        = 31;
    localparam int HOLD_CYCLES     = 120;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int RANDOM_PIXELS   = 850;

    // register index past the end of the map, and the unused format code
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

    // tracks the frame scan and keeps the boxes still owed by the block
    class ink_box_tracker;
        logic [FMT_W-1:0] fmt;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        int unsigned      cur_col;
        int unsigned      cur_row;
        int unsigned      min_col;
        int unsigned      min_row;
        int unsigned      max_col;
        int unsigned      max_row;
        bit               seen_ink;
        t_box             pending_boxes[$];
        int               mismatches;

        function new();
            fmt        = FMT_RGBA;
            width_reg  = CFG_W'(1);
            height_reg = CFG_W'(1);
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            cur_col  = 0;
            cur_row  = 0;
            min_col  = 0;
            min_row  = 0;
            max_col  = 0;
            max_row  = 0;
            seen_ink = 1'b0;
        endfunction

        function int unsigned clamp_dim(logic [CFG_W-1:0] v);
            if (v == 0) begin
                return 1;
            end
            if (v > DEF_MAX_DIM) begin
                return DEF_MAX_DIM;
            end
            return 32'(v);
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_FORMAT: fmt        = data[FMT_W-1:0];
                REG_WIDTH:  width_reg  = data;
                REG_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [BAND_W-1:0] b0, logic [BAND_W-1:0] b1,
                                 logic [BAND_W-1:0] b2, logic [BAND_W-1:0] b3);
            logic ink;
            t_box box;
            case (fmt)
                FMT_L8:   ink = |b0;
                FMT_RGBA: ink = |{b0, b1, b2, b3};
                default:  ink = |{b0, b1, b2};
            endcase
            if (ink) begin
                if (!seen_ink) begin
                    min_col  = cur_col;
                    max_col  = cur_col;
                    min_row  = cur_row;
                    max_row  = cur_row;
                    seen_ink = 1'b1;
                end else begin
                    if (cur_col < min_col) min_col = cur_col;
                    if (cur_col > max_col) max_col = cur_col;
                    if (cur_row < min_row) min_row = cur_row;
                    if (cur_row > max_row) max_row = cur_row;
                end
            end
            if (cur_col + 1 < clamp_dim(width_reg)) begin
                cur_col++;
                return;
            end
            cur_col = 0;
            if (cur_row + 1 < clamp_dim(height_reg)) begin
                cur_row++;
                return;
            end
            box.found  = seen_ink;
            box.left   = seen_ink ? min_col[BOX_W-1:0] : '0;
            box.top    = seen_ink ? min_row[BOX_W-1:0] : '0;
            box.right  = seen_ink ? max_col[BOX_W-1:0] : '0;
            box.bottom = seen_ink ? max_row[BOX_W-1:0] : '0;
            pending_boxes.push_back(box);
            clear_frame();
        endfunction

        function void check_field(string field, logic [BOX_W-1:0] want,
                                  logic [BOX_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void match_box(t_box got);
            t_box want;
            if (pending_boxes.size() == 0) begin
                $display("%0t: box with none expected, found %0d box %0d %0d %0d %0d",
                         $time, got.found, got.left, got.top, got.right, got.bottom);
                mismatches++;
                return;
            end
            want = pending_boxes.pop_front();
            check_field("found", want.found, got.found);
            check_field("box_left", want.left, got.left);
            check_field("box_top", want.top, got.top);
            check_field("box_right", want.right, got.right);
            check_field("box_bottom", want.bottom, got.bottom);
        endfunction
    endclass

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [BAND_W-1:0] i_band_zero  = '0;
    logic [BAND_W-1:0] i_band_one   = '0;
    logic [BAND_W-1:0] i_band_two   = '0;
    logic [BAND_W-1:0] i_band_three = '0;
    logic              i_cfg_valid  = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_W-1:0]  i_cfg_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic              o_found;
    logic [BOX_W-1:0]  o_box_left;
    logic [BOX_W-1:0]  o_box_top;
    logic [BOX_W-1:0]  o_box_right;
    logic [BOX_W-1:0]  o_box_bottom;

    ink_box_tracker tracker = new();
    int  pixels_sent  = 0;
    int  quiet_cycles = 0;
    bit  gaps_on      = 1'b1;
    bit  hold_go      = 1'b0;

    nonzero_pixel_bounding_box dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_band_zero  (i_band_zero),
        .i_band_one   (i_band_one),
        .i_band_two   (i_band_two),
        .i_band_three (i_band_three),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_right  (o_box_right),
        .o_box_bottom (o_box_bottom)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sample all three channels on the same edge the block does
    always @(posedge i_clk) begin : monitor
        bit progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                tracker.take_pixel(i_band_zero, i_band_one, i_band_two, i_band_three);
                progress = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.set_reg(i_cfg_index, i_cfg_data);
                progress = 1'b1;
            end
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                tracker.match_box({o_found, o_box_left, o_box_top, o_box_right,
                                   o_box_bottom});
                progress = 1'b1;
            end
        end
        quiet_cycles = progress ? 0 : quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_CYCLES);
        $display("FAIL");
        $finish;
    end

    // result side: random stall, plus a long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_left = HOLD_CYCLES;
                hold_go   = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // valid stays up between back-to-back requests; it drops only in a gap
    task automatic send_pixel(input logic [BAND_W-1:0] b0, input logic [BAND_W-1:0] b1,
                              input logic [BAND_W-1:0] b2, input logic [BAND_W-1:0] b3);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_band_zero  <= b0;
        i_band_one   <= b1;
        i_band_two   <= b2;
        i_band_three <= b3;
        do @(posedge i_clk); while (o_in_stall);
        pixels_sent++;
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (tracker.pending_boxes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers change only with the block idle and its pipeline empty
    task automatic setup_frame(input logic [FMT_W-1:0] fmt, input logic [CFG_W-1:0] w,
                               input logic [CFG_W-1:0] h);
        logic [CFG_W-1:0] fmt_word;
        stop_sending();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        fmt_word             = CFG_W'($urandom);
        fmt_word[FMT_W-1:0]  = fmt;
        if ($urandom_range(3) == 0) begin
            write_reg(REG_SPARE, CFG_W'($urandom));
        end
        write_reg(REG_FORMAT, fmt_word);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic send_random_pixel(input int ink_pct);
        logic [BAND_W-1:0] band [4];
        foreach (band[k]) band[k] = '0;
        if ($urandom_range(99) < ink_pct) begin
            case ($urandom_range(2))
                // a lone band: may be blank in the narrower formats
                0: band[2'($urandom_range(3))] = BAND_W'($urandom_range(255, 1));
                1: foreach (band[k]) band[k] = BAND_W'($urandom);
                default: foreach (band[k]) band[k] = $urandom_range(1) ? 8'hFF : 8'h00;
            endcase
        end
        send_pixel(band[0], band[1], band[2], band[3]);
    endtask

    task automatic send_frame(input int ink_pct);
        repeat (tracker.clamp_dim(tracker.width_reg) * tracker.clamp_dim(tracker.height_reg))
            send_random_pixel(ink_pct);
    endtask

    initial begin : stimulus
        int phase;
        int start_count;
        int ink_pct;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: rgba, one pixel per frame; alpha alone is ink
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h01);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // l8 ignores the colour bands
        setup_frame(FMT_L8, 11'd3, 11'd2);
        send_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h01, 8'h00, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'h80, 8'h00, 8'h00, 8'h00);

        // unused format code acts as rgb; zero width counts as one
        setup_frame(FMT_SPARE, 11'd0, 11'd2);
        send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h01, 8'h00);

        // write to an index past the map must be ignored
        setup_frame(FMT_RGB, 11'd2, 11'd2);
        write_reg(REG_SPARE, 11'h7FF);
        send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
        send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
        send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'h80, 8'h00, 8'h00);

        phase       = 0;
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS || phase < 7) begin
            phase++;
            gaps_on = !(phase inside {[5:7]});
            if (phase == 3) begin
                // one-pixel frames back up behind a stalled result
                setup_frame(FMT_L8, 11'd1, 11'd1);
                hold_go = 1'b1;
                repeat (40) send_random_pixel(50);
            end else begin
                setup_frame(FMT_W'($urandom_range(3)),
                            CFG_W'(($urandom_range(9) == 0) ? $urandom_range(40, 11)
                                                            : $urandom_range(10, 0)),
                            CFG_W'($urandom_range(6, 0)));
                repeat ($urandom_range(4, 1)) begin
                    case ($urandom_range(3))
                        0:       ink_pct = 0;
                        1:       ink_pct = 5;
                        2:       ink_pct = 35;
                        default: ink_pct = 90;
                    endcase
                    send_frame(ink_pct);
                    if ($urandom_range(4) == 0) begin
                        stop_sending();
                        wait_drained();
                    end
                end
            end
        end
        gaps_on = 1'b1;

        stop_sending();
        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_boxes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
